// ----- rtl/core/gqs_pkg.sv -----
// Shared types and constants for the GF(2^m) quadratic solver.
// No dependencies; imported by every module of the block.
package gqs_pkg;

  // Width of the degree register and of degree counters.
  localparam int DEG_W = 7;
  // Multiplier bits consumed per clock.
  localparam int DIGITS = 8;

  // Configuration register indexes.
  localparam logic [7:0] REG_FIELD_DEGREE = 8'd0;
  localparam logic [7:0] REG_MODULUS_LOW  = 8'd1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_S,
    OP_MUL_V,
    OP_CHECK,
    OP_RINIT,
    OP_ACC,
    OP_SQ_C,
    OP_MUL_Z,
    OP_SQ_U
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INV_TEST,
    ST_INV_SQ,
    ST_INV_MUL,
    ST_CHECK,
    ST_RINIT,
    ST_R_TEST,
    ST_R_ACC,
    ST_R_SQC,
    ST_R_MULZ,
    ST_R_SQU,
    ST_EMIT
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t  op;
    logic start;
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic prod_one;
    logic k_lt_m;
  } dp_status_t;

endpackage

// ----- rtl/core/gqs_mul.sv -----
// Digit-serial GF(2^m) multiplier, DIGITS bits of the second operand per cycle.
// Depends on gqs_pkg.
module gqs_mul #(
  parameter int W = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [W-1:0]               a,
  input  logic [W-1:0]               b,
  input  logic [gqs_pkg::DEG_W-1:0]  deg,
  input  logic [W-1:0]               msk,
  input  logic [W-1:0]               red,
  input  logic [W-1:0]               topm,
  output logic                       busy,
  output logic                       done,
  output logic [W-1:0]               prod
);
  import gqs_pkg::*;

  logic [W-1:0]     a_r, b_r, r_r;
  logic [W-1:0]     r_nxt, b_nxt;
  logic [DEG_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, done_r;

  // Up to DIGITS Horner steps: r = r*x mod f, plus a when the next bit of b is set.
  always_comb begin
    logic top;
    r_nxt   = r_r;
    b_nxt   = b_r;
    cnt_nxt = cnt_r;
    top     = 1'b0;
    for (int j = 0; j < DIGITS; j++) begin
      if (cnt_nxt != '0) begin
        top   = |(r_nxt & topm);
        r_nxt = (r_nxt << 1) & msk;
        if (top) r_nxt = r_nxt ^ red;
        if (b_nxt[W-1]) r_nxt = r_nxt ^ a_r;
        b_nxt   = b_nxt << 1;
        cnt_nxt = cnt_nxt - DEG_W'(1);
      end
    end
  end

  // Control bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_nxt == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operand and partial product registers; b is left aligned so bit m-1 sits at the top.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b << (DEG_W'(W) - deg);
      r_r   <= '0;
      cnt_r <= deg;
    end else if (busy_r) begin
      r_r   <= r_nxt;
      b_r   <= b_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = r_r;

endmodule

// ----- rtl/core/gqs_datapath.sv -----
// Datapath of the quadratic solver: field setup, operand registers, shared multiplier.
// Depends on gqs_pkg and gqs_mul.
module gqs_datapath #(
  parameter int W = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gqs_pkg::ctrl_cmd_t         cmd,
  input  logic [gqs_pkg::DEG_W-1:0]  field_degree,
  input  logic [W-1:0]               modulus_low,
  input  logic [W-1:0]               rhs_value,
  output gqs_pkg::dp_status_t        status,
  output logic [W-1:0]               root_value,
  output logic                       found
);
  import gqs_pkg::*;

  logic [DEG_W-1:0] m_r, k_r, m_cl;
  logic [W-1:0]     msk_r, red_r, topm_r;
  logic [W-1:0]     msk_c, odd_c, red_c, t_c;
  logic [W-1:0]     t_r, s_r, v_r, c_r, ct_r, acc_r, up_r, z_r;
  logic             ok_r;
  logic [W-1:0]     mul_a, mul_b, prod;
  logic             mul_busy, mul_done;

  // Clamp the degree and build the field masks.
  always_comb begin
    if (field_degree == '0) m_cl = DEG_W'(1);
    else if (field_degree > DEG_W'(W)) m_cl = DEG_W'(W);
    else m_cl = field_degree;
    for (int i = 0; i < W; i++) begin
      msk_c[i] = (DEG_W'(i) < m_cl);
      odd_c[i] = (i % 2 == 1);
    end
    red_c = modulus_low & msk_c;
    // Odd-index part of f reduced mod f; x^m folds back to red when m is odd.
    t_c = (red_c & odd_c) ^ (m_cl[0] ? red_c : '0);
  end

  // Operand selection for the multiplier.
  always_comb begin
    case (cmd.op)
      OP_SQ_S:  begin mul_a = s_r;  mul_b = s_r;   end
      OP_MUL_V: begin mul_a = v_r;  mul_b = s_r;   end
      OP_CHECK: begin mul_a = v_r;  mul_b = t_r;   end
      OP_SQ_C:  begin mul_a = c_r;  mul_b = c_r;   end
      OP_MUL_Z: begin mul_a = c_r;  mul_b = acc_r; end
      OP_SQ_U:  begin mul_a = up_r; mul_b = up_r;  end
      default:  begin mul_a = '0;   mul_b = '0;    end
    endcase
  end

  gqs_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .a     (mul_a),
    .b     (mul_b),
    .deg   (m_r),
    .msk   (msk_r),
    .red   (red_r),
    .topm  (topm_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  // Register updates for the load, round-init and accumulate operations and multiplier write-back.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      m_r    <= m_cl;
      msk_r  <= msk_c;
      red_r  <= red_c;
      topm_r <= msk_c ^ (msk_c >> 1);
      t_r    <= t_c;
      s_r    <= t_c;
      v_r    <= W'(1);
      c_r    <= rhs_value & msk_c;
      ct_r   <= rhs_value & msk_c;
      k_r    <= DEG_W'(1);
      ok_r   <= 1'b0;
    end else if (cmd.op == OP_RINIT) begin
      acc_r <= '0;
      up_r  <= v_r;
      z_r   <= '0;
      k_r   <= DEG_W'(1);
    end else if (cmd.op == OP_ACC) begin
      acc_r <= acc_r ^ up_r;
    end else if (mul_done) begin
      case (cmd.op)
        OP_SQ_S:  s_r <= prod;
        OP_MUL_V: begin
          v_r <= prod;
          k_r <= k_r + DEG_W'(1);
        end
        OP_CHECK: ok_r <= (prod == W'(1));
        OP_SQ_C:  begin
          c_r  <= prod;
          ct_r <= ct_r ^ prod;
        end
        OP_MUL_Z: z_r <= z_r ^ prod;
        OP_SQ_U:  begin
          up_r <= prod;
          k_r  <= k_r + DEG_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Status back to the controller.
  assign status.mul_busy = mul_busy;
  assign status.mul_done = mul_done;
  assign status.prod_one = (prod == W'(1));
  assign status.k_lt_m   = (k_r < m_r);

  // A root exists when the inverse v checked valid and the trace of c is zero.
  assign found      = ok_r && (ct_r == '0);
  assign root_value = found ? z_r : '0;

endmodule

// ----- rtl/core/gqs_ctrl.sv -----
// Controller state machine sequencing inversion, check and solver rounds.
// Depends on gqs_pkg.
module gqs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  gqs_pkg::dp_status_t  status,
  output gqs_pkg::ctrl_cmd_t   cmd,
  output logic                 idle,
  output logic                 emit
);
  import gqs_pkg::*;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  // Next state and commands. Multiply states launch once and wait for done.
  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    cmd.op       = OP_NONE;
    cmd.start    = 1'b0;
    emit         = 1'b0;
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_INV_TEST;
        end
      end
      ST_INV_TEST: state_nxt = status.k_lt_m ? ST_INV_SQ : ST_CHECK;
      ST_INV_SQ, ST_INV_MUL, ST_CHECK, ST_R_SQC, ST_R_MULZ, ST_R_SQU: begin
        unique case (state_r)
          ST_INV_SQ:  cmd.op = OP_SQ_S;
          ST_INV_MUL: cmd.op = OP_MUL_V;
          ST_CHECK:   cmd.op = OP_CHECK;
          ST_R_SQC:   cmd.op = OP_SQ_C;
          ST_R_MULZ:  cmd.op = OP_MUL_Z;
          default:    cmd.op = OP_SQ_U;
        endcase
        if (!launched_r) begin
          cmd.start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (status.mul_done) begin
          launched_nxt = 1'b0;
          unique case (state_r)
            ST_INV_SQ:  state_nxt = ST_INV_MUL;
            ST_INV_MUL: state_nxt = ST_INV_TEST;
            ST_CHECK:   state_nxt = status.prod_one ? ST_RINIT : ST_EMIT;
            ST_R_SQC:   state_nxt = ST_R_MULZ;
            ST_R_MULZ:  state_nxt = ST_R_SQU;
            default:    state_nxt = ST_R_TEST;
          endcase
        end
      end
      ST_RINIT: begin
        cmd.op    = OP_RINIT;
        state_nxt = ST_R_TEST;
      end
      ST_R_TEST: state_nxt = status.k_lt_m ? ST_R_ACC : ST_EMIT;
      ST_R_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = ST_R_SQC;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idle = (state_r == ST_IDLE);

`ifndef NO_ASSERTIONS
  // The multiplier is never restarted while it is still working.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !status.mul_busy)
    else $error("multiplier started while busy");

  // A multiplier completion only arrives for a launched operation.
  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    status.mul_done |-> launched_r)
    else $error("multiplier done without launch");

  // An accepted word always moves the controller into the inversion loop.
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    (idle && in_valid) |=> (state_r == ST_INV_TEST))
    else $error("load not followed by inversion");
`endif

endmodule

// ----- rtl/core/gf2m_quadratic_solver.sv -----
// Solver for z^2 + z = c in GF(2^m): one word at a time, no overlap between words.
// Each word takes up to 5m-4 products on the digit-serial multiplier plus control steps;
// the multiplier dominates. A new word is taken only after the last one is emitted;
// the output register lets a finished word wait while the solver is idle.
// Reset (rst_n low, synchronous): field_degree = 8, modulus_low = 0x1B, no word held.
module gf2m_quadratic_solver #(
  parameter int MAX_DEGREE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_rhs_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_root_value,
  output logic        out_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import gqs_pkg::*;

  logic [DEG_W-1:0]      field_degree_r;
  logic [63:0]           modulus_low_r;
  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic                  idle, emit, out_free;
  logic [MAX_DEGREE-1:0] dp_root;
  logic                  dp_found;
  logic                  out_valid_r, out_found_r;
  logic [63:0]           out_root_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_degree_r <= DEG_W'(8);
      modulus_low_r  <= 64'd27;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIELD_DEGREE) field_degree_r <= cfg_data[DEG_W-1:0];
      else if (cfg_index == REG_MODULUS_LOW) modulus_low_r <= cfg_data;
    end
  end

  assign in_stall = !idle;
  assign out_free = !out_valid_r || !out_stall;

  gqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle),
    .emit     (emit)
  );

  gqs_datapath #(.W(MAX_DEGREE)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .field_degree (field_degree_r),
    .modulus_low  (modulus_low_r[MAX_DEGREE-1:0]),
    .rhs_value    (in_rhs_value[MAX_DEGREE-1:0]),
    .status       (status),
    .root_value   (dp_root),
    .found        (dp_found)
  );

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_root_r  <= 64'(dp_root);
      out_found_r <= dp_found;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root_value = out_root_r;
  assign out_found      = out_found_r;

endmodule
